/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the fall detector.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define FFID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FFID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/ffid_pkg.sv */
// Types, codes and reset constants for the fall detector.
// No dependencies; taken in by the interfaces and the top level.
`default_nettype none

package ffid_pkg;

	localparam int ACCEL_W     = 16;
	localparam int STAMP_W     = 32;
	localparam int LEVEL_W     = 15;
	localparam int LEVEL_SQ_W  = 2 * LEVEL_W;
	localparam int MS_W        = 16;
	localparam int MAG_W       = 32;
	localparam int PHASE_W     = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int TIME_BITS_DEF = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FREE_FALL_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_MIN_MS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_MAX_MS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN_MS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX_MS   = 3'd5;

	// Reset values: 2.45 and 26.46 m/s^2 in 1/128 steps, and the default windows.
	localparam logic [LEVEL_W-1:0] FREE_FALL_LEVEL_RST = 15'd314;
	localparam logic [LEVEL_W-1:0] IMPACT_LEVEL_RST    = 15'd3387;
	localparam logic [LEVEL_SQ_W-1:0] FREE_FALL_SQ_RST = 30'd98596;
	localparam logic [LEVEL_SQ_W-1:0] IMPACT_SQ_RST    = 30'd11471769;
	localparam logic [MS_W-1:0] FALL_MIN_MS_RST   = 16'd80;
	localparam logic [MS_W-1:0] FALL_MAX_MS_RST   = 16'd300;
	localparam logic [MS_W-1:0] WINDOW_MIN_MS_RST = 16'd100;
	localparam logic [MS_W-1:0] WINDOW_MAX_MS_RST = 16'd1000;

	// Phase codes as they appear on the result channel.
	localparam logic [PHASE_W-1:0] CODE_NORMAL    = 2'd0;
	localparam logic [PHASE_W-1:0] CODE_FREE_FALL = 2'd1;
	localparam logic [PHASE_W-1:0] CODE_CONFIRMED = 2'd2;
	localparam logic [PHASE_W-1:0] CODE_IMPACT    = 2'd3;

	typedef enum logic [3:0] {
		PH_NORMAL    = 4'b0001,
		PH_FREE_FALL = 4'b0010,
		PH_CONFIRMED = 4'b0100,
		PH_IMPACT    = 4'b1000
	} phase_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		case (ph)
			PH_NORMAL:    code = CODE_NORMAL;
			PH_FREE_FALL: code = CODE_FREE_FALL;
			PH_CONFIRMED: code = CODE_CONFIRMED;
			PH_IMPACT:    code = CODE_IMPACT;
			default:      code = CODE_NORMAL;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

/* rtl/ffid_sample_if.sv */
// Sample channel: one accelerometer reading with its millisecond stamp.
// Depends on ffid_pkg for the field widths.
`default_nettype none

interface ffid_sample_if;
	import ffid_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [ACCEL_W-1:0] accel_x;
	logic signed [ACCEL_W-1:0] accel_y;
	logic signed [ACCEL_W-1:0] accel_z;
	logic [STAMP_W-1:0]        stamp_ms;

	modport source (output valid, accel_x, accel_y, accel_z, stamp_ms, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, stamp_ms, output ready);
endinterface

`default_nettype wire

/* rtl/ffid_result_if.sv */
// Result channel: fall report, phase after the sample and squared magnitude.
// Depends on ffid_pkg for the field widths.
`default_nettype none

interface ffid_result_if;
	import ffid_pkg::*;

	logic               valid;
	logic               ready;
	logic               fall_detected;
	logic [PHASE_W-1:0] phase;
	logic [MAG_W-1:0]   magnitude_sq;

	modport source (output valid, fall_detected, phase, magnitude_sq, input ready);
	modport sink (input valid, fall_detected, phase, magnitude_sq, output ready);
endinterface

`default_nettype wire

/* rtl/ffid_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on ffid_pkg for the field widths.
`default_nettype none

interface ffid_cfg_if;
	import ffid_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/free_fall_impact_detector.sv */
// Top level of the free-fall and impact detector.
// Depends on ffid_pkg, the three channel interfaces and assert_macros.svh.
//
//   Channel  Direction  Carries
//   sample   in         accel_x, accel_y, accel_z, stamp_ms
//   result   out        fall_detected, phase, magnitude_sq
//   cfg      in         index, data (register write, always ready)
//
// One sample is taken every clock cycle while the result channel is not stalled; it passes
// through the input register and then the result register, between which sit the three
// squares, their sum, the threshold compares and the phase update.
// Reset is asynchronous and active low; it loads the default thresholds and returns to normal.
// A stalled result holds the result register and, once the input register is also full,
// the sample channel drops ready; nothing is lost or repeated.
`default_nettype none

module free_fall_impact_detector #(
	parameter int TIME_BITS = ffid_pkg::TIME_BITS_DEF
) (
	input wire logic           clk,
	input wire logic           arst_n,
	ffid_sample_if.sink        sample,
	ffid_result_if.source      result,
	ffid_cfg_if.sink           cfg
);
	import ffid_pkg::*;

	`include "assert_macros.svh"

	// Time is kept at TIME_BITS; the stamp is widened or cut to that width.
	localparam int TW     = TIME_BITS;
	localparam int TW_EXT = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;

	// Configuration. The thresholds are kept squared, worked out as they are written.
	logic [LEVEL_SQ_W-1:0] free_sq_q;
	logic [LEVEL_SQ_W-1:0] impact_sq_q;
	logic [MS_W-1:0]       fall_min_q;
	logic [MS_W-1:0]       fall_max_q;
	logic [MS_W-1:0]       win_min_q;
	logic [MS_W-1:0]       win_max_q;
	logic [LEVEL_W-1:0]    cfg_level;
	logic [LEVEL_SQ_W-1:0] cfg_level_sq;

	assign cfg.ready    = 1'b1;
	assign cfg_level    = cfg.data[LEVEL_W-1:0];
	assign cfg_level_sq = LEVEL_SQ_W'(cfg_level) * LEVEL_SQ_W'(cfg_level);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_sq_q   <= FREE_FALL_SQ_RST;
			impact_sq_q <= IMPACT_SQ_RST;
			fall_min_q  <= FALL_MIN_MS_RST;
			fall_max_q  <= FALL_MAX_MS_RST;
			win_min_q   <= WINDOW_MIN_MS_RST;
			win_max_q   <= WINDOW_MAX_MS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FREE_FALL_LEVEL: free_sq_q   <= cfg_level_sq;
				REG_IMPACT_LEVEL:    impact_sq_q <= cfg_level_sq;
				REG_FALL_MIN_MS:     fall_min_q  <= cfg.data;
				REG_FALL_MAX_MS:     fall_max_q  <= cfg.data;
				REG_WINDOW_MIN_MS:   win_min_q   <= cfg.data;
				REG_WINDOW_MAX_MS:   win_max_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Handshake. The input register moves on whenever the result register is empty or
	// is being emptied in the same cycle, so a steady stream runs at one request a cycle while results are taken.
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic fire_s1;
	logic in_fire;

	assign advance      = !out_valid_q || result.ready;
	assign fire_s1      = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;
	assign in_fire      = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input register (payload only).
	logic signed [ACCEL_W-1:0] accel_x_s1;
	logic signed [ACCEL_W-1:0] accel_y_s1;
	logic signed [ACCEL_W-1:0] accel_z_s1;
	logic [STAMP_W-1:0]        stamp_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			accel_x_s1 <= sample.accel_x;
			accel_y_s1 <= sample.accel_y;
			accel_z_s1 <= sample.accel_z;
			stamp_s1   <= sample.stamp_ms;
		end
	end

	// Squared magnitude. Each square is at most 2^30, so the sum of three fits in 32 bits
	// and the sign bit of each product is always clear.
	logic signed [2*ACCEL_W-1:0] prod_x;
	logic signed [2*ACCEL_W-1:0] prod_y;
	logic signed [2*ACCEL_W-1:0] prod_z;
	logic [MAG_W-1:0]            mag;
	logic                        is_free;
	logic                        is_impact;

	assign prod_x    = (2*ACCEL_W)'(accel_x_s1) * (2*ACCEL_W)'(accel_x_s1);
	assign prod_y    = (2*ACCEL_W)'(accel_y_s1) * (2*ACCEL_W)'(accel_y_s1);
	assign prod_z    = (2*ACCEL_W)'(accel_z_s1) * (2*ACCEL_W)'(accel_z_s1);
	assign mag       = {1'b0, prod_x[2*ACCEL_W-2:0]} + {1'b0, prod_y[2*ACCEL_W-2:0]}
	                 + {1'b0, prod_z[2*ACCEL_W-2:0]};
	assign is_free   = mag < {{(MAG_W-LEVEL_SQ_W){1'b0}}, free_sq_q};
	assign is_impact = mag > {{(MAG_W-LEVEL_SQ_W){1'b0}}, impact_sq_q};

	// Phase machine state and the two time marks.
	phase_t        phase_q;
	phase_t        phase_nx;
	logic [TW-1:0] fall_start_q;
	logic [TW-1:0] confirm_q;
	logic [TW-1:0] fall_start_nx;
	logic [TW-1:0] confirm_nx;
	logic [TW_EXT-1:0] stamp_ext;
	logic [TW-1:0] now;
	logic [TW-1:0] dt_fall;
	logic [TW-1:0] dt_conf;
	logic          detected;

	// Durations wrap at the time width and are read as unsigned.
	assign stamp_ext = TW_EXT'(stamp_s1);
	assign now       = stamp_ext[TW-1:0];
	assign dt_fall   = now - fall_start_q;
	assign dt_conf   = now - confirm_q;

	always_comb begin
		phase_nx      = phase_q;
		fall_start_nx = fall_start_q;
		confirm_nx    = confirm_q;
		detected      = 1'b0;
		case (phase_q)
			PH_NORMAL: begin
				if (is_free) begin
					phase_nx      = PH_FREE_FALL;
					fall_start_nx = now;
				end
			end
			PH_FREE_FALL: begin
				// Leaving free fall: too short goes back to normal, otherwise it is confirmed.
				if (!is_free) begin
					if (dt_fall < TW'(fall_min_q)) begin
						phase_nx = PH_NORMAL;
					end else begin
						phase_nx   = PH_CONFIRMED;
						confirm_nx = now;
					end
				end else if (dt_fall > TW'(fall_max_q)) begin
					phase_nx = PH_NORMAL;
				end
			end
			PH_CONFIRMED: begin
				// An early impact is ignored; running past the window wins over an impact.
				if (dt_conf > TW'(win_max_q)) begin
					phase_nx = PH_NORMAL;
				end else if (is_impact && dt_conf >= TW'(win_min_q)) begin
					phase_nx = PH_IMPACT;
				end
			end
			PH_IMPACT: begin
				// The report sample ignores both thresholds and clears the marks.
				detected      = 1'b1;
				phase_nx      = PH_NORMAL;
				fall_start_nx = '0;
				confirm_nx    = '0;
			end
			default: begin
				phase_nx = PH_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_NORMAL;
			fall_start_q <= '0;
			confirm_q    <= '0;
		end else if (fire_s1) begin
			phase_q      <= phase_nx;
			fall_start_q <= fall_start_nx;
			confirm_q    <= confirm_nx;
		end
	end

	// Result register (payload only).
	logic               detected_q;
	logic [PHASE_W-1:0] phase_code_q;
	logic [MAG_W-1:0]   mag_q;

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			detected_q   <= detected;
			phase_code_q <= phase_code(phase_nx);
			mag_q        <= mag;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.fall_detected = detected_q;
	assign result.phase         = phase_code_q;
	assign result.magnitude_sq  = mag_q;

	// A sample taken in impact seen must be reported as a fall in the next result.
	`FFID_ASSERT_NEXT(a_report_after_impact, fire_s1 && phase_q == PH_IMPACT,
		result.valid && result.fall_detected, "impact seen did not report a fall")
	// Normal can never jump straight to impact seen.
	`FFID_ASSERT_NEXT(a_no_skip_to_impact, fire_s1 && phase_q == PH_NORMAL,
		result.phase != CODE_IMPACT, "normal went straight to impact seen")
	// A sample taken in free fall must not flag a fall; only the report sample may.
	`FFID_ASSERT_NEXT(a_no_report_in_free_fall, fire_s1 && phase_q == PH_FREE_FALL,
		!result.fall_detected, "fall reported while in free fall")

endmodule

`default_nettype wire
